// ===== design/plist_pkg.sv =====
package plist_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int CNT_W  = 7;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int GROUP  = 8;
	localparam int NGROUP = DEPTH / GROUP;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_READ   = 2'd1;
	localparam cmd_t CMD_REMOVE = 2'd2;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADPOS = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	typedef struct packed {
		cmd_t               command;
		logic [POS_W-1:0]   position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		status_t            status;
		logic [CNT_W-1:0]   length;
	} rsp_t;

	// Shift/select control for the cell row.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

	// Per-request outcome carried down the pipeline.
	typedef struct packed {
		logic             rd_ok;
		status_t          status;
		logic [CNT_W-1:0] length;
	} exec_res_t;

endpackage

// ===== design/positional_list_insert_remove.sv =====
// Positional list: an ordered sequence of up to DEPTH signed 32-bit values.
//
// Request channel (req_valid / req_stall / req): one command per request.
//   Insert puts req.value after position k (k = 0 makes it the front).
//   Read returns the value at 1-based position k (k = 0 reads the front).
//   Remove deletes the value at 1-based position k.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
//   request, in order, with a status (ok, bad position, empty, full), the
//   list length after the command, and read_value for a successful read.
// Throughput: one request per cycle, sustained unless a stalled response
//   backs up the pipeline. Every cell compares its index with the position
//   and shifts by one in the same cycle, so the list is current for the next
//   request right behind it. A response passes the input register (decode
//   and shift), the read-tree register and the response register.
// Reset clears the length and empties the pipeline; stored values are not
//   cleared since only entries below the length are ever read.
// A stalled response holds; the pipeline keeps filling its bubbles and
//   raises req_stall once all three stages hold requests.
module positional_list_insert_remove import plist_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic      v_s1;
	req_t      req_s1;
	logic      v_s2;
	exec_res_t res_s2;
	logic      rsp_v_q;
	rsp_t      rsp_q;

	logic      out_free;
	logic      s2_adv;
	logic      s1_adv;
	logic      fire;

	cell_ctl_t ctl;
	exec_res_t res;
	logic [NGROUP-1:0][DATA_W-1:0] grp_s2;
	logic [DATA_W-1:0] rd_or;

	// stage advance: a stage moves when it is empty or the next one moves
	assign out_free = !rsp_v_q || !rsp_stall;
	assign s2_adv   = !v_s2 || out_free;
	assign s1_adv   = !v_s1 || s2_adv;
	assign fire     = v_s1 && s2_adv;

	assign req_stall = !s1_adv;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && req_valid) begin
			req_s1 <= req;
		end
	end

	// decode against the current length; commit the count on fire
	plist_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.ctl    (ctl),
		.res    (res)
	);

	// cell row: shift on fire, capture per-group read selects into stage 2
	plist_cells u_cells (
		.clk     (clk),
		.fire    (fire),
		.load_s2 (s2_adv),
		.ctl     (ctl),
		.value   (req_s1.value),
		.grp_s2  (grp_s2)
	);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			res_s2 <= res;
		end
	end

	// last level of the read tree
	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NGROUP; g++) begin
			rd_or = rd_or | grp_s2[g];
		end
	end

	// response register; drop the read data unless the read succeeded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (out_free) begin
			rsp_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			rsp_q.read_value <= res_s2.rd_ok ? rd_or : '0;
			rsp_q.status     <= res_s2.status;
			rsp_q.length     <= res_s2.length;
		end
	end

endmodule

// ===== design/plist_exec.sv =====
module plist_exec import plist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  req_t      req,
	output cell_ctl_t ctl,
	output exec_res_t res
);

	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] pos_m1;
	logic             pos_past;
	logic             empty;
	logic             full;

	assign pos_m1   = req.position - POS_W'(1);
	assign pos_past = req.position > count_q;
	assign empty    = count_q == CNT_W'(0);
	assign full     = count_q == CNT_W'(DEPTH);

	always_comb begin
		ctl        = '0;
		res.rd_ok  = 1'b0;
		res.status = ST_OK;
		res.length = count_q;
		case (req.command)
			CMD_INSERT: begin
				ctl.idx = req.position[IDX_W-1:0];
				if (pos_past) begin
					res.status = ST_BADPOS;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					ctl.ins    = 1'b1;
					res.length = count_q + CNT_W'(1);
				end
			end
			CMD_READ: begin
				ctl.idx = (req.position == POS_W'(0)) ? IDX_W'(0) : pos_m1[IDX_W-1:0];
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (pos_past) begin
					res.status = ST_BADPOS;
				end else begin
					res.rd_ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				ctl.idx = pos_m1[IDX_W-1:0];
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (req.position == POS_W'(0) || pos_past) begin
					res.status = ST_BADPOS;
				end else begin
					ctl.rem    = 1'b1;
					res.length = count_q - CNT_W'(1);
				end
			end
			default: begin
				res.status = ST_BADPOS;
			end
		endcase
	end

	// advance the count only when the request leaves the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= res.length;
		end
	end

endmodule

// ===== design/plist_cells.sv =====
module plist_cells import plist_pkg::*; (
	input  logic                               clk,
	input  logic                               fire,
	input  logic                               load_s2,
	input  cell_ctl_t                          ctl,
	input  logic [DATA_W-1:0]                  value,
	output logic [NGROUP-1:0][DATA_W-1:0]      grp_s2
);

	logic [DATA_W-1:0] cell_q [DEPTH];
	logic [DATA_W-1:0] cell_nxt [DEPTH];
	logic [NGROUP-1:0][DATA_W-1:0] grp_or;

	// each cell looks only at its neighbors and its own index
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] next;
		if (i > 0) begin : g_prev
			assign prev = cell_q[i-1];
		end else begin : g_front
			assign prev = cell_q[i];
		end
		if (i < DEPTH - 1) begin : g_next
			assign next = cell_q[i+1];
		end else begin : g_back
			assign next = cell_q[i];
		end

		always_comb begin
			cell_nxt[i] = cell_q[i];
			if (ctl.ins) begin
				if (IDX_W'(i) == ctl.idx) begin
					cell_nxt[i] = value;
				end else if (IDX_W'(i) > ctl.idx) begin
					cell_nxt[i] = prev;
				end
			end else if (ctl.rem) begin
				if (IDX_W'(i) >= ctl.idx) begin
					cell_nxt[i] = next;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (fire && (ctl.ins || ctl.rem)) begin
				cell_q[i] <= cell_nxt[i];
			end
		end
	end

	// first level of the read tree: one selected cell per group, or zero
	always_comb begin
		grp_or = '0;
		for (int g = 0; g < NGROUP; g++) begin
			for (int j = 0; j < GROUP; j++) begin
				if (IDX_W'(g * GROUP + j) == ctl.idx) begin
					grp_or[g] = grp_or[g] | cell_q[g * GROUP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			grp_s2 <= grp_or;
		end
	end

endmodule

// ===== design/plist_chk.sv =====
module plist_chk import plist_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.length <= CNT_W'(DEPTH))
		else $error("length beyond capacity");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
		else $error("read data on a failed command");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status != ST_FULL || rsp.length == CNT_W'(DEPTH))
			&& (rsp.status != ST_EMPTY || rsp.length == CNT_W'(0)))
		else $error("full or empty status disagrees with length");

endmodule

bind positional_list_insert_remove plist_chk u_plist_chk (.*);

// ===== tb/tb_top.sv =====
module tb_top import plist_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Command code that the package leaves unnamed: the block must refuse it.
	localparam cmd_t CMD_UNUSED = 2'd3;

	// Random requests after the directed opening.
	localparam int RANDOM_REQUESTS = 1700;

	// Worst case per request: the longest idle gap on the request side, the longest
	// stall on the response side and the trip through the pipe. Take it many times
	// over so that only a hang trips the limit.
	localparam int CYCLE_LIMIT = 400000;

	// Traffic shapes for the random part: grow toward full, shrink toward
	// empty, or wander around the current length.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_WANDER} traffic_mix_t;

	// Shadow list and the responses it predicts, front of the list at index 0.
	class list_scoreboard;
		logic signed [DATA_W-1:0] held[$];
		rsp_t due[$];
		int mismatches;

		function int held_count();
			return held.size();
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Apply an accepted request to the shadow list and queue its response.
		function void note_request(req_t r);
			rsp_t e;
			int k;
			e = '0;
			e.status = ST_OK;
			k = int'(r.position);
			case (r.command)
				CMD_INSERT: begin
					if (k > held.size())
						e.status = ST_BADPOS;
					else if (held.size() >= DEPTH)
						e.status = ST_FULL;
					else
						held.insert(k, r.value);
				end
				CMD_READ: begin
					if (held.size() == 0)
						e.status = ST_EMPTY;
					else if (k > held.size())
						e.status = ST_BADPOS;
					else
						e.read_value = held[(k == 0) ? 0 : k - 1];
				end
				CMD_REMOVE: begin
					if (held.size() == 0)
						e.status = ST_EMPTY;
					else if (k == 0 || k > held.size())
						e.status = ST_BADPOS;
					else
						held.delete(k - 1);
				end
				default: begin
					e.status = ST_BADPOS;
				end
			endcase
			e.length = CNT_W'(held.size());
			due.insert(due.size(), e);
		endfunction

		// Compare an accepted response with the oldest prediction.
		function void check_response(rsp_t got);
			rsp_t e;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response: val %0d st %0d len %0d",
						$realtime, got.read_value, got.status, got.length);
				return;
			end
			e = due[0];
			due.delete(0);
			if (got.read_value !== e.read_value || got.status !== e.status ||
					got.length !== e.length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp val %0d st %0d len %0d, got val %0d st %0d len %0d",
						$realtime, e.read_value, e.status, e.length,
						got.read_value, got.status, got.length);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	list_scoreboard sb;
	int cycles;
	int req_burst;
	int rsp_burst;

	positional_list_insert_remove DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	// Bail out if the run hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Draw the idle cycles before the next request or response. Mostly a uniform
	// draw, but now and then open a burst with no idling at all.
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// Hold the request for a random gap, then present it until it is taken.
	// Entered and left on a falling edge; valid stays high between requests
	// when no gap is drawn.
	task automatic send_request(input req_t r);
		int gap;
		gap = draw_wait(req_burst);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_fields(input cmd_t c, input int p, input logic signed [DATA_W-1:0] v);
		req_t r;
		r.command = c;
		r.position = POS_W'(p);
		r.value = v;
		send_request(r);
	endtask

	// Mostly plain data, sometimes an extreme of the signed range.
	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 19))
			0: return {1'b0, {(DATA_W-1){1'b1}}};
			1: return {1'b1, {(DATA_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Build one random request shaped by the traffic mix. Positions mostly
	// land inside the current list so that the shifts get exercised; the
	// rest cover the whole field, well past the end.
	function automatic req_t draw_request(traffic_mix_t mix);
		req_t r;
		int w;
		int n;
		n = sb.held_count();
		w = $urandom_range(0, 99);
		case (mix)
			MIX_GROW:
				r.command = (w < 75) ? CMD_INSERT : (w < 90) ? CMD_READ :
					(w < 98) ? CMD_REMOVE : CMD_UNUSED;
			MIX_SHRINK:
				r.command = (w < 75) ? CMD_REMOVE : (w < 90) ? CMD_READ :
					(w < 98) ? CMD_INSERT : CMD_UNUSED;
			default:
				r.command = (w < 34) ? CMD_INSERT : (w < 67) ? CMD_READ :
					(w < 98) ? CMD_REMOVE : CMD_UNUSED;
		endcase
		if ($urandom_range(0, 99) < 15)
			r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		else if (r.command == CMD_REMOVE && n > 0)
			r.position = POS_W'($urandom_range(1, n));
		else
			r.position = POS_W'($urandom_range(0, n));
		r.value = draw_value();
		return r;
	endfunction

	// Response side: stall for a random number of cycles, then release and
	// take the next response as soon as it shows up.
	initial begin
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = draw_wait(rsp_burst);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			sb.check_response(rsp);
			@(negedge clk);
		end
	end

	initial begin
		traffic_mix_t mix;
		int sent;
		int steps;
		int extra;

		sb = new();
		cycles = 0;
		req_burst = 0;
		rsp_burst = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: refusals on the empty list first.
		send_fields(CMD_READ, 0, 0);
		send_fields(CMD_REMOVE, 1, 0);
		send_fields(CMD_REMOVE, 0, 0);
		send_fields(CMD_INSERT, 1, 0);
		// Build a short list with the value extremes: front, back, middle.
		send_fields(CMD_INSERT, 0, 32'sh7FFFFFFF);
		send_fields(CMD_INSERT, 1, 32'sh80000000);
		send_fields(CMD_INSERT, 0, 0);
		send_fields(CMD_INSERT, 2, -1);
		// Reads: front by zero, last, middle, then past the end.
		send_fields(CMD_READ, 0, 0);
		send_fields(CMD_READ, 4, 0);
		send_fields(CMD_READ, 2, 0);
		send_fields(CMD_READ, 5, 0);
		send_fields(CMD_READ, 127, 0);
		// Bad positions for remove and insert, and the unused command.
		send_fields(CMD_REMOVE, 0, 0);
		send_fields(CMD_REMOVE, 5, 0);
		send_fields(CMD_REMOVE, 127, 0);
		send_fields(CMD_INSERT, 127, 32'sh5A5A5A5A);
		send_fields(CMD_UNUSED, 0, 0);
		send_fields(CMD_UNUSED, 127, -1);
		// Drain: middle, last, front, then read, remove the last one and refuse a read on empty.
		send_fields(CMD_REMOVE, 2, 0);
		send_fields(CMD_REMOVE, 3, 0);
		send_fields(CMD_REMOVE, 1, 0);
		send_fields(CMD_READ, 1, 0);
		send_fields(CMD_REMOVE, 1, 0);
		send_fields(CMD_READ, 1, 0);

		// Random part in segments. Grow runs until the list is full or 250 requests
		// have gone, then pushes a few more requests against the full check; shrink
		// does the same toward empty; wander stays put for a while.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			mix = traffic_mix_t'($urandom_range(0, 2));
			steps = 0;
			if (mix == MIX_WANDER) begin
				extra = $urandom_range(20, 80);
				while (steps < extra) begin
					send_request(draw_request(mix));
					steps++;
				end
			end else begin
				while (steps < 250 && ((mix == MIX_GROW) ? sb.held_count() < DEPTH :
						sb.held_count() > 0)) begin
					send_request(draw_request(mix));
					steps++;
				end
				extra = $urandom_range(1, 5);
				repeat (extra) begin
					send_request(draw_request(mix));
					steps++;
				end
			end
			sent += steps;
		end

		// Drop valid and let the pipe empty out.
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/plist_pkg.sv
design/plist_exec.sv
design/plist_cells.sv
design/positional_list_insert_remove.sv
design/plist_chk.sv
tb/tb_top.sv
